### rtl/glzw_pkg.sv
// Shared constants, item types and code arithmetic for the GIF LZW encoder.
package glzw_pkg;

  localparam int CODE_LIMIT   = 4096;
  localparam int SYMBOL_COUNT = 256;
  localparam int CODE_W       = $clog2(CODE_LIMIT);
  localparam int SYM_W        = $clog2(SYMBOL_COUNT);
  localparam int KEY_W        = CODE_W + SYM_W;
  localparam int DICT_DEPTH   = CODE_LIMIT * SYMBOL_COUNT;
  localparam int NEXT_W       = CODE_W + 1;
  localparam int WIDTH_W      = 4;
  localparam int SIZE_W       = 4;
  localparam int PIXEL_W      = 8;
  localparam int BYTE_W       = 8;
  localparam int MASK_W       = 16;
  localparam int MAX_CODES    = 4;
  localparam int PEND_IDX_W   = $clog2(MAX_CODES);
  localparam int PEND_CNT_W   = $clog2(MAX_CODES + 1);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int ACC_W        = 24;
  localparam int CNT_W        = 5;

  localparam logic [SIZE_W-1:0]  SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0]  SIZE_MAX   = SIZE_W'(8);
  localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(8);
  localparam logic [WIDTH_W-1:0] WIDTH_CAP  = WIDTH_W'(15);

  // One pixel as it travels from the front to the dictionary engine
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             start;
    logic             eoi;
  } item_t;

  // One code for the packer; last closes the image's code stream
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } code_t;

  // Saturate the programmed size, then lower it to fit the symbol alphabet
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] cfg);
    logic [SIZE_W-1:0] s;
    s = cfg;
    if (s < SIZE_MIN) s = SIZE_MIN;
    if (s > SIZE_MAX) s = SIZE_MAX;
    for (int i = 0; i < 6; i++) begin
      if (s > SIZE_MIN && (MASK_W'(1) << s) > MASK_W'(SYMBOL_COUNT)) s = s - SIZE_W'(1);
    end
    return s;
  endfunction

  function automatic logic [CODE_W-1:0] clear_code(input logic [SIZE_W-1:0] s);
    return CODE_W'(1) << s;
  endfunction

  // Code width after a restart at size s
  function automatic logic [WIDTH_W-1:0] restart_width(input logic [SIZE_W-1:0] s);
    logic [WIDTH_W-1:0] w;
    logic [NEXT_W-1:0]  nc;
    nc = NEXT_W'(clear_code(s)) + NEXT_W'(2);
    w  = WIDTH_W'(s) + WIDTH_W'(1);
    if (MASK_W'(nc) >= (MASK_W'(1) << w)) w = w + WIDTH_W'(1);
    return w;
  endfunction

  // Width growth after one code has gone out
  function automatic logic [WIDTH_W-1:0] grow_width(input logic [WIDTH_W-1:0] w,
                                                    input logic [NEXT_W-1:0] nc);
    logic [MASK_W-1:0] mask;
    mask = (MASK_W'(1) << w) - MASK_W'(1);
    if (mask < MASK_W'(nc) && w < WIDTH_CAP) return w + WIDTH_W'(1);
    return w;
  endfunction

endpackage

### rtl/glzw_ram.sv
// Generic simple dual-port RAM with registered, write-first read.
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

endmodule

### rtl/glzw_front.sv
// Input side: accept pixels, mask and tag image starts, queue them for the engine.
module glzw_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [glzw_pkg::PIXEL_W-1:0] pixel,
  input  logic                        end_of_image,
  input  logic [glzw_pkg::SIZE_W-1:0] code_size,
  output logic                        q_valid,
  output glzw_pkg::item_t             q_item,
  input  logic                        q_pop
);

  glzw_pkg::item_t                  qmem [glzw_pkg::QDEPTH];
  logic [glzw_pkg::QPTR_W-1:0]      wr_ptr;
  logic [glzw_pkg::QPTR_W-1:0]      rd_ptr;
  logic [glzw_pkg::QCNT_W-1:0]      count;
  logic                             start;
  logic [glzw_pkg::SYM_W-1:0]       sym_mask;
  glzw_pkg::item_t                  push_item;
  logic                             push;
  logic                             pop;

  assign in_ready = count != glzw_pkg::QCNT_W'(glzw_pkg::QDEPTH);
  assign q_valid  = count != '0;
  assign q_item   = qmem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    sym_mask       = glzw_pkg::SYM_W'(glzw_pkg::clear_code(glzw_pkg::eff_size(code_size))
                                      - glzw_pkg::CODE_W'(1));
    push_item.sym   = pixel[glzw_pkg::SYM_W-1:0] & sym_mask;
    push_item.start = start;
    push_item.eoi   = end_of_image;
  end

  always_ff @(posedge clk) begin
    if (push) qmem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      start  <= 1'b1;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + glzw_pkg::QPTR_W'(1);
        // the item after the last pixel opens a new image
        start  <= end_of_image;
      end
      if (pop) rd_ptr <= rd_ptr + glzw_pkg::QPTR_W'(1);
      if (push && !pop) begin
        count <= count + glzw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - glzw_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/glzw_dict.sv
// Dictionary engine: look up prefix and symbol, add codes, produce the code sequence.
module glzw_dict (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [glzw_pkg::SIZE_W-1:0] code_size,
  input  logic                        q_valid,
  input  glzw_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        c_valid,
  output glzw_pkg::code_t             c_item,
  input  logic                        c_ready
);

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_DECIDE} state_t;

  state_t                            state;
  glzw_pkg::item_t                   cur;
  logic [glzw_pkg::KEY_W-1:0]        cur_key;
  logic [glzw_pkg::CODE_W-1:0]       prefix;
  logic [glzw_pkg::NEXT_W-1:0]       next_code;
  logic [glzw_pkg::WIDTH_W-1:0]      code_width;
  logic [glzw_pkg::NEXT_W-1:0]       first_code;

  logic [glzw_pkg::CODE_W-1:0]       pend_code  [glzw_pkg::MAX_CODES];
  logic [glzw_pkg::WIDTH_W-1:0]      pend_width [glzw_pkg::MAX_CODES];
  logic [glzw_pkg::PEND_CNT_W-1:0]   pend_cnt;
  logic                              pend_final;

  logic [glzw_pkg::CODE_W-1:0]       dict_rdata;
  logic [glzw_pkg::KEY_W-1:0]        key_rdata;

  logic [glzw_pkg::SIZE_W-1:0]       size;
  logic [glzw_pkg::CODE_W-1:0]       clear;
  logic [glzw_pkg::CODE_W-1:0]       end_code;
  logic [glzw_pkg::NEXT_W-1:0]       rst_next;
  logic [glzw_pkg::WIDTH_W-1:0]      rst_width;
  logic                              hit;

  logic [glzw_pkg::CODE_W-1:0]       prefix_next;
  logic [glzw_pkg::NEXT_W-1:0]       next_code_next;
  logic [glzw_pkg::WIDTH_W-1:0]      code_width_next;
  logic [glzw_pkg::NEXT_W-1:0]       first_code_next;
  logic [glzw_pkg::CODE_W-1:0]       lst_code  [glzw_pkg::MAX_CODES];
  logic [glzw_pkg::WIDTH_W-1:0]      lst_width [glzw_pkg::MAX_CODES];
  logic [glzw_pkg::PEND_CNT_W-1:0]   lst_cnt;
  logic                              add_entry;

  logic                              decide;
  logic                              issue;
  logic [glzw_pkg::KEY_W-1:0]        rd_key;

  assign size      = glzw_pkg::eff_size(code_size);
  assign clear     = glzw_pkg::clear_code(size);
  assign end_code  = clear + glzw_pkg::CODE_W'(1);
  assign rst_next  = glzw_pkg::NEXT_W'(clear) + glzw_pkg::NEXT_W'(2);
  assign rst_width = glzw_pkg::restart_width(size);

  // A stored code is trusted only if it was handed out since the last restart and
  // the code-to-key table confirms this key; this stands in for a cleared valid map.
  always_comb begin
    if (glzw_pkg::NEXT_W'(dict_rdata) >= first_code &&
        glzw_pkg::NEXT_W'(dict_rdata) < next_code && key_rdata == cur_key) begin
      hit = 1'b1;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    prefix_next     = prefix;
    next_code_next  = next_code;
    code_width_next = code_width;
    first_code_next = first_code;
    add_entry       = 1'b0;
    lst_cnt         = '0;
    for (int i = 0; i < glzw_pkg::MAX_CODES; i++) begin
      lst_code[i]  = '0;
      lst_width[i] = '0;
    end
    if (cur.start) begin
      lst_code[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]]  = clear;
      lst_width[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]] = rst_width;
      lst_cnt         = lst_cnt + glzw_pkg::PEND_CNT_W'(1);
      code_width_next = glzw_pkg::grow_width(rst_width, rst_next);
      next_code_next  = rst_next;
      first_code_next = rst_next;
      prefix_next     = glzw_pkg::CODE_W'(cur.sym);
    end else if (hit) begin
      prefix_next = dict_rdata;
    end else begin
      lst_code[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]]  = prefix;
      lst_width[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]] = code_width;
      lst_cnt         = lst_cnt + glzw_pkg::PEND_CNT_W'(1);
      code_width_next = glzw_pkg::grow_width(code_width, next_code);
      add_entry       = 1'b1;
      next_code_next  = next_code + glzw_pkg::NEXT_W'(1);
      prefix_next     = glzw_pkg::CODE_W'(cur.sym);
      // table full: send a clear code and restart
      if (next_code_next >= glzw_pkg::NEXT_W'(glzw_pkg::CODE_LIMIT)) begin
        lst_code[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]]  = clear;
        lst_width[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]] = code_width_next;
        lst_cnt         = lst_cnt + glzw_pkg::PEND_CNT_W'(1);
        code_width_next = rst_width;
        next_code_next  = rst_next;
        first_code_next = rst_next;
      end
    end
    if (cur.eoi) begin
      lst_code[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]]  = prefix_next;
      lst_width[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]] = code_width_next;
      lst_cnt         = lst_cnt + glzw_pkg::PEND_CNT_W'(1);
      code_width_next = glzw_pkg::grow_width(code_width_next, next_code_next);
      lst_code[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]]  = end_code;
      lst_width[lst_cnt[glzw_pkg::PEND_IDX_W-1:0]] = code_width_next;
      lst_cnt         = lst_cnt + glzw_pkg::PEND_CNT_W'(1);
      code_width_next = glzw_pkg::grow_width(code_width_next, next_code_next);
    end
  end

  assign decide = (state == ST_DECIDE) && (pend_cnt == '0);
  assign issue  = q_valid && ((state == ST_IDLE) || decide);
  assign q_pop  = issue;
  // look up with the prefix that this cycle's decision leaves behind
  assign rd_key = {(state == ST_DECIDE) ? prefix_next : prefix, q_item.sym};

  assign c_valid     = pend_cnt != '0;
  assign c_item.code  = pend_code[0];
  assign c_item.width = pend_width[0];
  assign c_item.last  = pend_final && (pend_cnt == glzw_pkg::PEND_CNT_W'(1));

  glzw_ram #(
    .WIDTH (glzw_pkg::CODE_W),
    .DEPTH (glzw_pkg::DICT_DEPTH)
  ) u_dict_ram (
    .clk   (clk),
    .we    (decide && add_entry),
    .waddr (cur_key),
    .wdata (next_code[glzw_pkg::CODE_W-1:0]),
    .re    (issue),
    .raddr (rd_key),
    .rdata (dict_rdata)
  );

  glzw_ram #(
    .WIDTH (glzw_pkg::KEY_W),
    .DEPTH (glzw_pkg::CODE_LIMIT)
  ) u_key_ram (
    .clk   (clk),
    .we    (decide && add_entry),
    .waddr (next_code[glzw_pkg::CODE_W-1:0]),
    .wdata (cur_key),
    .re    (state == ST_WAIT),
    .raddr (dict_rdata),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_cnt   <= '0;
      pend_final <= 1'b0;
      prefix     <= '0;
      next_code  <= '0;
      code_width <= '0;
      first_code <= '0;
    end else begin
      if (c_valid && c_ready) begin
        for (int i = 0; i < glzw_pkg::MAX_CODES - 1; i++) begin
          pend_code[i]  <= pend_code[i+1];
          pend_width[i] <= pend_width[i+1];
        end
        pend_cnt <= pend_cnt - glzw_pkg::PEND_CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur     <= q_item;
            cur_key <= rd_key;
            state   <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          // hold until the previous item's codes have all gone to the packer
          if (pend_cnt == '0) begin
            prefix     <= prefix_next;
            next_code  <= next_code_next;
            code_width <= code_width_next;
            first_code <= first_code_next;
            pend_code  <= lst_code;
            pend_width <= lst_width;
            pend_cnt   <= lst_cnt;
            pend_final <= cur.eoi;
            if (q_valid) begin
              cur     <= q_item;
              cur_key <= rd_key;
              state   <= ST_WAIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/glzw_pack.sv
// Bit packer: append codes LSB first and hand out bytes through an output register.
module glzw_pack (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         c_valid,
  input  glzw_pkg::code_t              c_item,
  output logic                         c_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [glzw_pkg::BYTE_W-1:0]  data_byte,
  output logic                         last_byte
);

  logic [glzw_pkg::ACC_W-1:0]  acc;
  logic [glzw_pkg::CNT_W-1:0]  cnt;
  logic                        closing;

  logic                        slot_free;
  logic                        emit_full;
  logic                        emit_flush;
  logic                        emit;
  logic                        is_last;
  logic [glzw_pkg::ACC_W-1:0]  base_acc;
  logic [glzw_pkg::CNT_W-1:0]  base_cnt;
  logic                        closing_after;
  logic [glzw_pkg::MASK_W-1:0] code_mask;
  logic [glzw_pkg::MASK_W-1:0] code_bits;
  logic                        take;

  localparam logic [glzw_pkg::CNT_W-1:0] BYTE_BITS = glzw_pkg::CNT_W'(glzw_pkg::BYTE_W);

  always_comb begin
    slot_free  = !out_valid || out_ready;
    emit_full  = cnt >= BYTE_BITS;
    emit_flush = closing && (cnt != '0) && !emit_full;
    emit       = slot_free && (emit_full || emit_flush);
    is_last    = closing && (emit_flush || cnt == BYTE_BITS);
    if (emit && is_last) begin
      base_acc = '0;
      base_cnt = '0;
    end else if (emit) begin
      base_acc = acc >> glzw_pkg::BYTE_W;
      base_cnt = cnt - BYTE_BITS;
    end else begin
      base_acc = acc;
      base_cnt = cnt;
    end
    closing_after = closing && !(emit && is_last);
    // take a new code only once the previous one has drained below a byte
    c_ready   = !closing_after && (base_cnt < BYTE_BITS);
    take      = c_valid && c_ready;
    code_mask = (glzw_pkg::MASK_W'(1) << c_item.width) - glzw_pkg::MASK_W'(1);
    code_bits = glzw_pkg::MASK_W'(c_item.code) & code_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      closing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        acc <= base_acc | (glzw_pkg::ACC_W'(code_bits) << base_cnt);
        cnt <= base_cnt + glzw_pkg::CNT_W'(c_item.width);
      end else begin
        acc <= base_acc;
        cnt <= base_cnt;
      end
      closing <= closing_after || (take && c_item.last);
      if (emit) begin
        out_valid <= 1'b1;
        data_byte <= acc[glzw_pkg::BYTE_W-1:0];
        last_byte <= is_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/gif_lzw_encoder.sv
// Top level of the GIF LZW encoder: configuration register, front, engine, packer.
//
// Pixels enter on in_valid/in_ready with pixel and end_of_image; end_of_image
// marks the last pixel of an image. Packed code stream bytes leave on
// out_valid/out_ready as data_byte, with last_byte set on the image's final byte.
// min_code_size is written through cfg_valid/cfg_ready (always ready); the user
// must write it only between images, which the block does not enforce. It sets
// the clear and end codes and the starting code width. Each pixel passes the
// dictionary engine's read keyed by prefix and symbol, then a read of the
// code-to-key table to confirm the entry, then a decision in which the next
// pixel's lookup is issued. Pixels that emit several codes (table restart, image
// end) hold the next decision until all their codes have gone to the packer.
// A four-item queue sits between the input and the engine, and the output
// register lets a waiting byte stand while work continues; when the receiver
// stalls, the packer, then the engine, then the queue fill and in_ready drops.
// Reset clears all control state and sets min_code_size to 8; the dictionary
// needs no clearing pass, so pixels are accepted from the first cycle.
module gif_lzw_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [glzw_pkg::SIZE_W-1:0]   min_code_size,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [glzw_pkg::PIXEL_W-1:0]  pixel,
  input  logic                          end_of_image,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [glzw_pkg::BYTE_W-1:0]   data_byte,
  output logic                          last_byte
);

  logic [glzw_pkg::SIZE_W-1:0] code_size;
  logic                        q_valid;
  glzw_pkg::item_t             q_item;
  logic                        q_pop;
  logic                        c_valid;
  glzw_pkg::code_t             c_item;
  logic                        c_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_size <= glzw_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      code_size <= min_code_size;
    end
  end

  glzw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel        (pixel),
    .end_of_image (end_of_image),
    .code_size    (code_size),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  glzw_dict u_dict (
    .clk       (clk),
    .rst       (rst),
    .code_size (code_size),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .c_valid   (c_valid),
    .c_item    (c_item),
    .c_ready   (c_ready)
  );

  glzw_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .c_valid   (c_valid),
    .c_item    (c_item),
    .c_ready   (c_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_byte (data_byte),
    .last_byte (last_byte)
  );

endmodule
